### src/cbq_pkg.sv
package cbq_pkg;

  localparam int SECTIONS_DEF   = 5;
  localparam int STATE_BITS_DEF = 24;

  localparam int COEF_W       = 16;
  localparam int COEF_FRAC    = 14;
  localparam int ROM_SECTIONS = 5;
  localparam int TERMS        = 6;
  localparam int SAMPLE_W     = 14;
  localparam int TDATA_W      = 16;

  // term codes within one section
  localparam logic [2:0] TERM_B0   = 3'd0;
  localparam logic [2:0] TERM_B1   = 3'd1;
  localparam logic [2:0] TERM_B2   = 3'd2;
  localparam logic [2:0] TERM_A1   = 3'd3;
  localparam logic [2:0] TERM_A2   = 3'd4;
  localparam logic [2:0] TERM_GAIN = 3'd5;

  localparam logic signed [COEF_W-1:0] ONE_Q14 = 16'sd16384;

  // b0, b1, b2, a1, a2, gain per section, Q2.14
  localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_SECTIONS*TERMS] = '{
    16'sd16384, 16'sd0, -16'sd16384, -16'sd17735, 16'sd14433, 16'sd3548,
    16'sd16384, 16'sd0, -16'sd16384,  -16'sd5076, 16'sd14060, 16'sd3548,
    16'sd16384, 16'sd0, -16'sd16384, -16'sd14273, 16'sd11454, 16'sd3243,
    16'sd16384, 16'sd0, -16'sd16384,  -16'sd6886, 16'sd10931, 16'sd3243,
    16'sd16384, 16'sd0, -16'sd16384, -16'sd10331, 16'sd10094, 16'sd3145
  };

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } cbq_ctrl_t;

  // sections past the table pass their input through
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [4:0] sec,
                                                       input logic [2:0] k);
    logic [4:0] idx;
    idx = 5'(sec * 5'd6 + 5'(k));
    if (sec >= 5'(ROM_SECTIONS)) begin
      return (k == TERM_B0 || k == TERM_GAIN) ? ONE_Q14 : '0;
    end
    return COEF_ROM[idx];
  endfunction

endpackage

### src/cbq_hist_mem.sv
module cbq_hist_mem #(
  parameter int SECTIONS = cbq_pkg::SECTIONS_DEF,
  parameter int WIDTH    = 4 * cbq_pkg::STATE_BITS_DEF,
  parameter int ADDR_W   = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0]    mem [SECTIONS];
  logic [SECTIONS-1:0] vld_r;
  logic [WIDTH-1:0]    data_r;
  logic                dvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  // a row never written reads as zero history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      dvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        dvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = dvld_r ? data_r : '0;

endmodule

### src/cbq_mac.sv
module cbq_mac #(
  parameter int STATE_BITS = cbq_pkg::STATE_BITS_DEF
) (
  input  logic                         clk,
  input  cbq_pkg::cbq_ctrl_t           ctrl,
  input  logic signed [16:0]           coef_i,
  input  logic signed [STATE_BITS-1:0] opnd_i,
  output logic signed [STATE_BITS-1:0] acc_q,
  output logic signed [STATE_BITS-1:0] prod_q
);

  localparam int PW    = STATE_BITS + 17;
  localparam int ACC_W = STATE_BITS + 20;
  localparam int FR    = cbq_pkg::COEF_FRAC;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (FR - 1);
  localparam logic signed [ACC_W-1:0] ACC_HI =
    {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (FR - 1);
  localparam logic signed [PW-1:0] P_HI =
    {{(PW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] P_LO = ~P_HI;

  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [PW-1:0]    prod_rnd;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef_i * opnd_i;
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, drop the coefficient fraction, clamp to the state range
  always_comb begin
    acc_rnd = (acc_r + ACC_HALF) >>> FR;
    if (acc_rnd > ACC_HI) begin
      acc_q = ACC_HI[STATE_BITS-1:0];
    end else if (acc_rnd < ACC_LO) begin
      acc_q = ACC_LO[STATE_BITS-1:0];
    end else begin
      acc_q = acc_rnd[STATE_BITS-1:0];
    end

    prod_rnd = (prod_r + P_HALF) >>> FR;
    if (prod_rnd > P_HI) begin
      prod_q = P_HI[STATE_BITS-1:0];
    end else if (prod_rnd < P_LO) begin
      prod_q = P_LO[STATE_BITS-1:0];
    end else begin
      prod_q = prod_rnd[STATE_BITS-1:0];
    end
  end

endmodule

### src/cascaded_biquad_iir_filter_core.sv
// Five-by-default direct-form-I biquad cascade for 14-bit offset-binary samples.
// One multiplier works through the six products of each section (b0, b1, b2,
// a1, a2 terms, then the section gain), stepping through S_MAC, S_ACC, S_ROUND,
// S_GAIN and S_GSAT per section. The result register is loaded from S_OUT,
// which holds while a result waits in the output register. Section history
// lives in a one-port-read, one-port-write memory with one row per section;
// a new sample is taken once the previous one has reached the output register.
module cascaded_biquad_iir_filter_core #(
  parameter int SECTIONS   = cbq_pkg::SECTIONS_DEF,
  parameter int STATE_BITS = cbq_pkg::STATE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cbq_pkg::TDATA_W-1:0] in_tdata,   // [13:0] adc_sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cbq_pkg::TDATA_W-1:0] out_tdata   // [13:0] dac_sample
);

  localparam int SB     = STATE_BITS;
  localparam int FRAC   = SB - 4;
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int ROW_W  = 4 * SB;
  localparam int IN_UP  = (FRAC >= 13) ? FRAC - 13 : 0;
  localparam int IN_DN  = (FRAC >= 13) ? 0 : 13 - FRAC;
  localparam logic signed [SB-1:0] IN_HALF = (IN_DN > 0) ? SB'(1) : '0;
  localparam int OUT_DN = (FRAC >= 13) ? FRAC - 13 : 0;
  localparam int OUT_SH = (FRAC > 13) ? FRAC - 14 : 0;
  localparam logic signed [SB+1:0] OUT_HALF = (FRAC > 13) ? ((SB+2)'(1) <<< OUT_SH) : '0;
  localparam logic signed [SB+1:0] OUT_MID  = (SB+2)'(8192);
  localparam logic signed [SB+1:0] OUT_MAX  = (SB+2)'(16383);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_ACC, S_ROUND, S_GAIN, S_GSAT, S_OUT
  } state_t;

  state_t                   state_r;
  logic [SEC_W-1:0]         sec_r;
  logic [2:0]               k_r;
  logic signed [SB-1:0]     v_r;
  logic signed [SB-1:0]     w_r;
  logic                     out_valid_r;
  logic [cbq_pkg::SAMPLE_W-1:0] out_data_r;

  logic                     in_fire;
  logic                     last_sec;
  logic                     rd_en;
  logic [SEC_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [ROW_W-1:0]         wr_data;
  logic [ROW_W-1:0]         row;
  logic signed [SB-1:0]     x1, x2, y1, y2;
  cbq_pkg::cbq_ctrl_t       ctrl;
  logic signed [15:0]       rom_c;
  logic signed [16:0]       coef;
  logic signed [SB-1:0]     opnd;
  logic signed [SB-1:0]     acc_q;
  logic signed [SB-1:0]     prod_q;
  logic signed [15:0]       cen;
  logic signed [SB-1:0]     cen_ext;
  logic signed [SB-1:0]     v_in;
  logic signed [SB+1:0]     ov;
  logic signed [SB+1:0]     os;
  logic [cbq_pkg::SAMPLE_W-1:0] dac;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign last_sec   = (sec_r == SEC_W'(SECTIONS - 1));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cbq_pkg::TDATA_W-cbq_pkg::SAMPLE_W){1'b0}}, out_data_r};

  // row layout, low to high: x1, x2, y1, y2
  assign x1 = row[SB-1:0];
  assign x2 = row[2*SB-1:SB];
  assign y1 = row[3*SB-1:2*SB];
  assign y2 = row[4*SB-1:3*SB];

  // fetch the first row on accept, the next row while the gain settles
  assign rd_en   = in_fire || (state_r == S_GSAT && !last_sec);
  assign rd_addr = (state_r == S_IDLE) ? '0 : sec_r + 1'b1;
  assign wr_en   = (state_r == S_ROUND);
  assign wr_data = {y1, acc_q, x1, v_r};

  always_comb begin
    cen     = signed'({2'b00, in_tdata[cbq_pkg::SAMPLE_W-1:0]}) - 16'sd8192;
    cen_ext = SB'(cen);
    if (IN_DN == 0) begin
      v_in = cen_ext <<< IN_UP;
    end else begin
      v_in = (cen_ext + IN_HALF) >>> IN_DN;
    end

    ov = (SB+2)'(v_r);
    if (FRAC >= 13) begin
      os = ((ov + OUT_HALF) >>> OUT_DN) + OUT_MID;
    end else begin
      os = (ov <<< 1) + OUT_MID;
    end
    if (os < 0) begin
      dac = '0;
    end else if (os > OUT_MAX) begin
      dac = '1;
    end else begin
      dac = os[cbq_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    ctrl  = '0;
    rom_c = cbq_pkg::coef_at(5'(sec_r), (state_r == S_GAIN) ? cbq_pkg::TERM_GAIN : k_r);
    coef  = 17'(rom_c);
    opnd  = v_r;
    unique case (state_r)
      S_MAC: begin
        ctrl.mul_en  = 1'b1;
        ctrl.acc_clr = (k_r == cbq_pkg::TERM_B0);
        ctrl.acc_en  = (k_r != cbq_pkg::TERM_B0);
        unique case (k_r)
          cbq_pkg::TERM_B0: opnd = v_r;
          cbq_pkg::TERM_B1: opnd = x1;
          cbq_pkg::TERM_B2: opnd = x2;
          cbq_pkg::TERM_A1: begin
            opnd = y1;
            coef = -17'(rom_c);
          end
          cbq_pkg::TERM_A2: begin
            opnd = y2;
            coef = -17'(rom_c);
          end
          default: opnd = v_r;
        endcase
      end
      S_ACC:   ctrl.acc_en = 1'b1;
      S_GAIN: begin
        ctrl.mul_en = 1'b1;
        opnd        = w_r;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sec_r       <= '0;
      k_r         <= cbq_pkg::TERM_B0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result word, else drop the one just taken
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            v_r     <= v_in;
            sec_r   <= '0;
            k_r     <= cbq_pkg::TERM_B0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (k_r == cbq_pkg::TERM_A2) begin
            state_r <= S_ACC;
          end
          k_r <= k_r + 3'd1;
        end
        S_ACC:   state_r <= S_ROUND;
        S_ROUND: begin
          w_r     <= acc_q;
          state_r <= S_GAIN;
        end
        S_GAIN:  state_r <= S_GSAT;
        S_GSAT: begin
          v_r <= prod_q;
          k_r <= cbq_pkg::TERM_B0;
          if (last_sec) begin
            state_r <= S_OUT;
          end else begin
            sec_r   <= sec_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_data_r <= dac;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  cbq_hist_mem #(
    .SECTIONS (SECTIONS),
    .WIDTH    (ROW_W),
    .ADDR_W   (SEC_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (sec_r),
    .wr_data (wr_data),
    .rd_data (row)
  );

  cbq_mac #(
    .STATE_BITS (SB)
  ) u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .coef_i (coef),
    .opnd_i (opnd),
    .acc_q  (acc_q),
    .prod_q (prod_q)
  );

endmodule

### src/cbq_checker.sv
module cbq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [cbq_pkg::TDATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a sample keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] == 2'b00)
    else $error("padding bits set in result word");

endmodule

bind cascaded_biquad_iir_filter_core cbq_checker u_cbq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
